// File: rtl/dtpg_pkg.sv
// shared constants, types and helper functions of the test pattern generator
package dtpg_pkg;

   // panel geometry
   localparam int DIM_MAX = 4096;
   localparam int POS_W   = $clog2(DIM_MAX);
   localparam int SIZE_W  = 13;
   localparam int SCALED_W = SIZE_W + 3;

   // payload widths
   localparam int RGB_W   = 24;
   localparam int LEVEL_W = 8;
   localparam int MODE_W  = 4;

   // configuration port
   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 2;
   localparam int ADDR_W    = REG_IDX_W + 2;

   localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_FILL   = 2'd3;

   localparam logic [MODE_W-1:0] MODE_RST    = 4'd0;
   localparam logic [SIZE_W-1:0] WIDTH_RST   = 13'd1920;
   localparam logic [SIZE_W-1:0] HEIGHT_RST  = 13'd1080;
   localparam logic [RGB_W-1:0]  FILL_RST    = 24'h000000;

   // pattern modes
   localparam logic [MODE_W-1:0] MODE_SOLID      = 4'd0;
   localparam logic [MODE_W-1:0] MODE_CROSSTALK  = 4'd1;
   localparam logic [MODE_W-1:0] MODE_FLICKER    = 4'd2;
   localparam logic [MODE_W-1:0] MODE_CHECKER    = 4'd3;
   localparam logic [MODE_W-1:0] MODE_BOX        = 4'd4;
   localparam logic [MODE_W-1:0] MODE_HRAMP_GREY = 4'd5;
   localparam logic [MODE_W-1:0] MODE_HRAMP_BLUE = 4'd8;
   localparam logic [MODE_W-1:0] MODE_VRAMP_GREY = 4'd9;
   localparam logic [MODE_W-1:0] MODE_VRAMP_BLUE = 4'd12;
   localparam logic [MODE_W-1:0] MODE_HBARS      = 4'd13;
   localparam logic [MODE_W-1:0] MODE_VBARS      = 4'd14;
   localparam logic [MODE_W-1:0] MODE_UNUSED     = 4'd15;

   // ramp tint select
   localparam logic [1:0] TINT_GREY  = 2'd0;
   localparam logic [1:0] TINT_RED   = 2'd1;
   localparam logic [1:0] TINT_GREEN = 2'd2;
   localparam logic [1:0] TINT_BLUE  = 2'd3;

   // colors
   localparam logic [RGB_W-1:0] COLOR_GREY    = 24'h7F7F7F;
   localparam logic [RGB_W-1:0] COLOR_DIM_MAG = 24'h7F007F;
   localparam logic [RGB_W-1:0] COLOR_DIM_GRN = 24'h007F00;
   localparam logic [RGB_W-1:0] COLOR_WHITE   = 24'hFFFFFF;
   localparam logic [RGB_W-1:0] COLOR_YELLOW  = 24'hFFFF00;
   localparam logic [RGB_W-1:0] COLOR_CYAN    = 24'h00FFFF;
   localparam logic [RGB_W-1:0] COLOR_GREEN   = 24'h00FF00;
   localparam logic [RGB_W-1:0] COLOR_MAGENTA = 24'hFF00FF;
   localparam logic [RGB_W-1:0] COLOR_RED     = 24'hFF0000;
   localparam logic [RGB_W-1:0] COLOR_BLUE    = 24'h0000FF;
   localparam logic [RGB_W-1:0] COLOR_BLACK   = 24'h000000;

   // band splits
   localparam int CHK_COLS   = 5;
   localparam int CHK_ROWS   = 8;
   localparam int BARS       = 8;
   localparam int BAR_IDX_W  = $clog2(BARS);

   // exact floor(x/5) for x below 2^16 as (x * recip) >> shift
   localparam int DIV5_RECIP_W = 16;
   localparam logic [DIV5_RECIP_W-1:0] DIV5_RECIP = 16'd52429;
   localparam int DIV5_SHIFT = 18;
   localparam int DIV5_PROD_W = SCALED_W + DIV5_RECIP_W;

   // ramp divider: one quotient bit per iteration
   localparam int RAMP_STEPS = LEVEL_W;
   localparam int STEP_CNT_W = $clog2(RAMP_STEPS);

   typedef struct packed {
      logic take_item;
      logic div_step;
      logic out_load_fast;
      logic out_load_ramp;
   } dtpg_cmd_type;

   typedef struct packed {
      logic ramp_mode;
   } dtpg_stat_type;

   function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      priority if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > SIZE_W'(DIM_MAX)) begin
         r = SIZE_W'(DIM_MAX);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [RGB_W-1:0] tint(input logic [LEVEL_W-1:0] lvl,
                                             input logic [1:0] sel);
      logic [RGB_W-1:0] r;
      unique case (sel)
         TINT_GREY:  r = {lvl, lvl, lvl};
         TINT_RED:   r = {lvl, 16'h0000};
         TINT_GREEN: r = {8'h00, lvl, 8'h00};
         TINT_BLUE:  r = {16'h0000, lvl};
      endcase
      return r;
   endfunction

   function automatic logic [RGB_W-1:0] bar_color(input logic [BAR_IDX_W-1:0] idx);
      logic [RGB_W-1:0] r;
      unique case (idx)
         3'd0: r = COLOR_WHITE;
         3'd1: r = COLOR_YELLOW;
         3'd2: r = COLOR_CYAN;
         3'd3: r = COLOR_GREEN;
         3'd4: r = COLOR_MAGENTA;
         3'd5: r = COLOR_RED;
         3'd6: r = COLOR_BLUE;
         3'd7: r = COLOR_BLACK;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/dtpg_if.sv
// valid/ready channel interfaces for the request and response beats
interface dtpg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface dtpg_rsp_if;
   import dtpg_pkg::*;
   logic             valid;
   logic             ready;
   logic [RGB_W-1:0] pixel_rgb;
   logic             line_end;
   logic             frame_end;

   modport source (output valid, output pixel_rgb, output line_end, output frame_end,
                   input ready);
   modport sink   (input valid, input pixel_rgb, input line_end, input frame_end,
                   output ready);
endinterface

// File: rtl/display_test_pattern_generator_core.sv
// throughput: one pixel per cycle in all non-ramp modes while the receiver is ready and
//   no register write is settling, set by the output register; ramp modes take no new
//   request until the eight-step shared level divider has loaded its pixel
// reset: synchronous, active high; raster returns to column 0 row 0, registers to
//   mode 0, 1920x1080, black fill; requests are held off after reset and after every
//   register write while the band edges are recomputed
module display_test_pattern_generator_core (
   input  logic                         clock,
   input  logic                         reset,
   dtpg_req_if.sink                     req_if,
   dtpg_rsp_if.source                   rsp_if,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [dtpg_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [dtpg_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [dtpg_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import dtpg_pkg::*;

   // register file outputs
   logic [MODE_W-1:0] cfg_mode;
   logic [SIZE_W-1:0] cfg_width;
   logic [SIZE_W-1:0] cfg_height;
   logic [RGB_W-1:0]  cfg_fill;
   logic              cfg_wr;

   // controller to datapath
   dtpg_cmd_type      cmd;
   dtpg_stat_type     stat;

   // apb register file: mode, width, height, fill color at 0x0, 0x4, 0x8, 0xc
   dtpg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_mode    (cfg_mode),
      .cfg_width   (cfg_width),
      .cfg_height  (cfg_height),
      .cfg_fill    (cfg_fill),
      .cfg_wr      (cfg_wr)
   );

   // controller owns both handshakes and the output register valid bit; a new request
   // beat can be taken in the cycle the pending response leaves, unless dividing or settling
   dtpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_wr    (cfg_wr),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: raster counters advance on the request beat, the pixel lands in
   // the output register either at once or after the ramp divider finishes
   dtpg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg_mode   (cfg_mode),
      .cfg_width  (cfg_width),
      .cfg_height (cfg_height),
      .cfg_fill   (cfg_fill),
      .cmd        (cmd),
      .stat       (stat),
      .restart    (req_if.restart),
      .pixel_rgb  (rsp_if.pixel_rgb),
      .line_end   (rsp_if.line_end),
      .frame_end  (rsp_if.frame_end)
   );

endmodule

// File: rtl/dtpg_csr.sv
// apb-style register file holding mode, panel size and fill color
module dtpg_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [dtpg_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [dtpg_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [dtpg_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready,
   output logic [dtpg_pkg::MODE_W-1:0]  cfg_mode,
   output logic [dtpg_pkg::SIZE_W-1:0]  cfg_width,
   output logic [dtpg_pkg::SIZE_W-1:0]  cfg_height,
   output logic [dtpg_pkg::RGB_W-1:0]   cfg_fill,
   output logic                         cfg_wr
);
   import dtpg_pkg::*;

   logic [MODE_W-1:0]    mode_ff;
   logic [SIZE_W-1:0]    width_ff;
   logic [SIZE_W-1:0]    height_ff;
   logic [RGB_W-1:0]     fill_ff;
   logic [REG_IDX_W-1:0] reg_idx;

   assign reg_idx    = csr_paddr[ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RST;
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         fill_ff   <= FILL_RST;
      end else if (cfg_wr) begin
         unique case (reg_idx)
            REG_MODE:   mode_ff   <= csr_pwdata[MODE_W-1:0];
            REG_WIDTH:  width_ff  <= csr_pwdata[SIZE_W-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[SIZE_W-1:0];
            REG_FILL:   fill_ff   <= csr_pwdata[RGB_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MODE:   csr_prdata = DATA_W'(mode_ff);
         REG_WIDTH:  csr_prdata = DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = DATA_W'(height_ff);
         REG_FILL:   csr_prdata = DATA_W'(fill_ff);
      endcase
   end

   assign cfg_mode   = mode_ff;
   assign cfg_width  = width_ff;
   assign cfg_height = height_ff;
   assign cfg_fill   = fill_ff;

endmodule

// File: rtl/dtpg_ctrl.sv
// controller: beat handshakes, ramp divider sequencing, output register valid
module dtpg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cfg_wr,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  dtpg_pkg::dtpg_stat_type stat,
   output dtpg_pkg::dtpg_cmd_type  cmd
);
   import dtpg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } ctrl_state_type;

   ctrl_state_type          state_ff, state_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    settle_ff, settle_in;
   logic                    out_free;
   logic                    accept;
   logic                    last_step;

   always_comb begin
      out_free  = ~out_valid_ff | rsp_ready;
      req_ready = (state_ff == ST_IDLE) & ~settle_ff & out_free;
      accept    = req_valid & req_ready;
      last_step = (cnt_ff == STEP_CNT_W'(RAMP_STEPS - 1));

      cmd.take_item     = accept;
      cmd.out_load_fast = accept & ~stat.ramp_mode;
      cmd.div_step      = (state_ff == ST_DIV);
      cmd.out_load_ramp = (state_ff == ST_DONE) & out_free;

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && stat.ramp_mode) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (last_step) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      cnt_in = (state_ff == ST_DIV) ? cnt_ff + STEP_CNT_W'(1) : '0;

      priority if (cmd.out_load_fast || cmd.out_load_ramp) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      // derived geometry registers lag a register write, so requests wait while they settle
      settle_in = cfg_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         settle_ff    <= 1'b1;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         settle_ff    <= settle_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

   a_cnt_only_in_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV) |-> (cnt_ff == '0))
      else $error("divider count running outside divide state");

   a_settle_after_write: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> !req_ready)
      else $error("request taken before derived geometry settled");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && last_step) |=> (state_ff == ST_DONE))
      else $error("ramp divide did not finish after its last step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load_fast || cmd.out_load_ramp) && out_valid_ff |-> rsp_ready)
      else $error("output register overwritten while still pending");

endmodule

// File: rtl/dtpg_dp.sv
// datapath: raster counters, band edges, pattern logic, ramp divider, output register
module dtpg_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [dtpg_pkg::MODE_W-1:0]  cfg_mode,
   input  logic [dtpg_pkg::SIZE_W-1:0]  cfg_width,
   input  logic [dtpg_pkg::SIZE_W-1:0]  cfg_height,
   input  logic [dtpg_pkg::RGB_W-1:0]   cfg_fill,
   input  dtpg_pkg::dtpg_cmd_type       cmd,
   output dtpg_pkg::dtpg_stat_type      stat,
   input  logic                         restart,
   output logic [dtpg_pkg::RGB_W-1:0]   pixel_rgb,
   output logic                         line_end,
   output logic                         frame_end
);
   import dtpg_pkg::*;

   // derived geometry, recomputed every cycle from the registers
   logic [SIZE_W-1:0] w_cl, h_cl;
   logic [SIZE_W-1:0] w_ff;
   logic [POS_W-1:0]  wm1_ff, hm1_ff, wm1_in, hm1_in;
   logic [POS_W-1:0]  w_q1_ff, w_q3_ff, h_q1_ff, h_q3_ff;
   logic [POS_W-1:0]  w_q1_in, w_q3_in, h_q1_in, h_q3_in;
   logic [POS_W-1:0]  col5_ff [CHK_COLS-1];
   logic [POS_W-1:0]  col5_in [CHK_COLS-1];
   logic [POS_W-1:0]  col8_ff [BARS-1];
   logic [POS_W-1:0]  col8_in [BARS-1];
   logic [POS_W-1:0]  row8_ff [BARS-1];
   logic [POS_W-1:0]  row8_in [BARS-1];

   // raster position
   logic [POS_W-1:0]  col_ff, row_ff, col_in, row_in;
   logic [POS_W-1:0]  c_raw, r_raw, c, r;
   logic              le_now, fe_now;

   // pattern
   logic              ramp_mode, ramp_horiz;
   logic [1:0]        tint_sel;
   logic              chk_par;
   logic [BAR_IDX_W-1:0] hbar_idx, vbar_idx;
   logic [RGB_W-1:0]  fast_pix;

   // ramp divider
   logic [SIZE_W-1:0]  rem_ff, rem_in;
   logic [SIZE_W-1:0]  dsize_ff;
   logic [LEVEL_W-1:0] quot_ff;
   logic [SIZE_W:0]    rem2;
   logic               q_bit;
   logic               le_hold_ff, fe_hold_ff;

   // output register
   logic [RGB_W-1:0]   pix_out_ff;
   logic               le_out_ff, fe_out_ff;

   always_comb begin
      logic [SCALED_W-1:0]    wk, hk, w3, h3;
      logic [DIV5_PROD_W-1:0] p5;
      w_cl = clamp_dim(cfg_width);
      h_cl = clamp_dim(cfg_height);
      wm1_in = POS_W'(w_cl - SIZE_W'(1));
      hm1_in = POS_W'(h_cl - SIZE_W'(1));
      w3 = SCALED_W'(w_cl) * SCALED_W'(3);
      h3 = SCALED_W'(h_cl) * SCALED_W'(3);
      w_q1_in = POS_W'(w_cl >> 2);
      h_q1_in = POS_W'(h_cl >> 2);
      w_q3_in = POS_W'(w3 >> 2);
      h_q3_in = POS_W'(h3 >> 2);
      for (int k = 0; k < BARS - 1; k++) begin
         wk = SCALED_W'(w_cl) * SCALED_W'(k + 1);
         hk = SCALED_W'(h_cl) * SCALED_W'(k + 1);
         col8_in[k] = POS_W'(wk >> BAR_IDX_W);
         row8_in[k] = POS_W'(hk >> BAR_IDX_W);
      end
      for (int k = 0; k < CHK_COLS - 1; k++) begin
         wk = SCALED_W'(w_cl) * SCALED_W'(k + 1);
         p5 = DIV5_PROD_W'(wk) * DIV5_PROD_W'(DIV5_RECIP);
         col5_in[k] = POS_W'(p5 >> DIV5_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_cl;
      wm1_ff  <= wm1_in;
      hm1_ff  <= hm1_in;
      w_q1_ff <= w_q1_in;
      w_q3_ff <= w_q3_in;
      h_q1_ff <= h_q1_in;
      h_q3_ff <= h_q3_in;
      col5_ff <= col5_in;
      col8_ff <= col8_in;
      row8_ff <= row8_in;
   end

   // position of this beat, clamped to a panel that may have shrunk
   always_comb begin
      c_raw  = restart ? '0 : col_ff;
      r_raw  = restart ? '0 : row_ff;
      c      = (c_raw > wm1_ff) ? wm1_ff : c_raw;
      r      = (r_raw > hm1_ff) ? hm1_ff : r_raw;
      le_now = (c == wm1_ff);
      fe_now = le_now & (r == hm1_ff);
      if (le_now) begin
         col_in = '0;
         row_in = fe_now ? '0 : r + POS_W'(1);
      end else begin
         col_in = c + POS_W'(1);
         row_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.take_item) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // combinational non-ramp patterns
   always_comb begin
      logic [BAR_IDX_W-1:0] hcnt, vcnt;
      logic                 par;
      ramp_mode  = (cfg_mode >= MODE_HRAMP_GREY) & (cfg_mode <= MODE_VRAMP_BLUE);
      ramp_horiz = (cfg_mode <= MODE_HRAMP_BLUE);
      // grey/red/green/blue order repeats with a spacing of four modes
      tint_sel   = 2'(cfg_mode - MODE_HRAMP_GREY);

      par  = 1'b0;
      hcnt = '0;
      vcnt = '0;
      for (int k = 0; k < CHK_COLS - 1; k++) begin
         par = par ^ (c >= col5_ff[k]);
      end
      for (int k = 0; k < BARS - 1; k++) begin
         par  = par ^ (r >= row8_ff[k]);
         hcnt = hcnt + BAR_IDX_W'(c >= col8_ff[k]);
         vcnt = vcnt + BAR_IDX_W'(r >= row8_ff[k]);
      end
      chk_par  = par;
      hbar_idx = hcnt;
      vbar_idx = vcnt;

      priority case (cfg_mode)
         MODE_SOLID:     fast_pix = cfg_fill;
         MODE_CROSSTALK: fast_pix = (r >= h_q1_ff && r < h_q3_ff &&
                                     c >= w_q1_ff && c < w_q3_ff) ? COLOR_BLACK : COLOR_GREY;
         MODE_FLICKER:   fast_pix = (c[0] ^ (r[0] & w_ff[0])) ? COLOR_DIM_GRN
                                                              : COLOR_DIM_MAG;
         MODE_CHECKER:   fast_pix = chk_par ? COLOR_WHITE : COLOR_BLACK;
         MODE_BOX:       fast_pix = (c == '0 || c == wm1_ff || r == '0 || r == hm1_ff)
                                    ? COLOR_WHITE : COLOR_BLACK;
         MODE_HBARS:     fast_pix = bar_color(hbar_idx);
         MODE_VBARS:     fast_pix = bar_color(vbar_idx);
         default:        fast_pix = COLOR_BLACK;
      endcase
   end

   assign stat.ramp_mode = ramp_mode;

   // ramp level floor(pos*256/size): restoring divide, one bit per step
   always_comb begin
      rem2  = {rem_ff, 1'b0};
      q_bit = (rem2 >= {1'b0, dsize_ff});
      rem_in = q_bit ? SIZE_W'(rem2 - {1'b0, dsize_ff}) : SIZE_W'(rem2);
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         rem_ff     <= ramp_horiz ? SIZE_W'(c) : SIZE_W'(r);
         dsize_ff   <= ramp_horiz ? w_ff : clamp_dim(cfg_height);
         quot_ff    <= '0;
         le_hold_ff <= le_now;
         fe_hold_ff <= fe_now;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[LEVEL_W-2:0], q_bit};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load_fast) begin
         pix_out_ff <= fast_pix;
         le_out_ff  <= le_now;
         fe_out_ff  <= fe_now;
      end else if (cmd.out_load_ramp) begin
         pix_out_ff <= tint(quot_ff, tint_sel);
         le_out_ff  <= le_hold_ff;
         fe_out_ff  <= fe_hold_ff;
      end
   end

   assign pixel_rgb = pix_out_ff;
   assign line_end  = le_out_ff;
   assign frame_end = fe_out_ff;

endmodule

// File: dv/tb_top.sv
// self-checking testbench for the display test pattern generator core
module tb_top;
   import dtpg_pkg::*;

   // run limits
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PIXEL_TARGET  = 1700;
   localparam int TAIL_CYCLES   = 16;
   localparam int LONG_HOLD     = 400;
   localparam int SIZE_CODE_MAX = (1 << SIZE_W) - 1;

   // bar colors left to right / top to bottom
   localparam logic [RGB_W-1:0] BAR_SEQUENCE [BARS] = '{
      COLOR_WHITE, COLOR_YELLOW, COLOR_CYAN, COLOR_GREEN,
      COLOR_MAGENTA, COLOR_RED, COLOR_BLUE, COLOR_BLACK
   };

   // how the two sides of the stream pause
   typedef enum int {
      FLOW_STEADY,
      FLOW_SENDER_GAPS,
      FLOW_RECEIVER_STALLS,
      FLOW_BOTH_PAUSE
   } flow_style_type;

   // one expected response beat
   typedef struct packed {
      logic [RGB_W-1:0] rgb;
      logic             line_end;
      logic             frame_end;
   } pixel_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   dtpg_req_if req_bus ();
   dtpg_rsp_if rsp_bus ();

   display_test_pattern_generator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow copies of the registers, updated on every write
   logic [MODE_W-1:0] shadow_mode   = MODE_RST;
   logic [SIZE_W-1:0] shadow_width  = WIDTH_RST;
   logic [SIZE_W-1:0] shadow_height = HEIGHT_RST;
   logic [RGB_W-1:0]  shadow_fill   = FILL_RST;

   // raster position of the next pixel as the generator should see it
   int scan_col = 0;
   int scan_row = 0;

   pixel_beat_type expected_pixels [$];

   int  error_count   = 0;
   int  pixels_sent   = 0;
   int  cycle_count   = 0;
   int  req_idle_pct  = 0;
   int  rsp_stall_pct = 0;
   bit  hold_request  = 1'b0;

   // 2-unit clock
   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // pixel predictor
   // ------------------------------------------------------------------

   // zero acts as one, anything past the panel limit as the limit
   function automatic int effective_size(input logic [SIZE_W-1:0] size_code);
      if (size_code == '0)
         return 1;
      if (size_code > SIZE_W'(DIM_MAX))
         return DIM_MAX;
      return int'(size_code);
   endfunction

   // how many band edges floor(size*k/n), k in 1..n-1, lie at or below pos
   function automatic int edges_passed(input int pos, input int size, input int n);
      int count;
      count = 0;
      for (int k = 1; k < n; k++) begin
         if (pos >= (size * k) / n)
            count++;
      end
      return count;
   endfunction

   // 256-level ramp position, saturating at full scale
   function automatic logic [LEVEL_W-1:0] ramp_step(input int pos, input int size);
      int level;
      level = (pos * 256) / size;
      if (level > 255)
         level = 255;
      return LEVEL_W'(level);
   endfunction

   function automatic logic [RGB_W-1:0] shade(input logic [LEVEL_W-1:0] level,
                                              input logic [1:0] channel);
      logic [RGB_W-1:0] grey;
      grey = {level, level, level};
      case (channel)
         TINT_RED:   return grey & 24'hFF0000;
         TINT_GREEN: return grey & 24'h00FF00;
         TINT_BLUE:  return grey & 24'h0000FF;
         default:    return grey;
      endcase
   endfunction

   function automatic logic [RGB_W-1:0] pattern_color(input int col, input int row,
                                                      input int w, input int h);
      logic inside_center;
      int   cell_sum;
      inside_center = (row >= h / 4) && (row < (h * 3) / 4) &&
                      (col >= w / 4) && (col < (w * 3) / 4);
      cell_sum = edges_passed(col, w, CHK_COLS) + edges_passed(row, h, CHK_ROWS);
      if (shadow_mode == MODE_SOLID)
         return shadow_fill;
      if (shadow_mode == MODE_CROSSTALK)
         return inside_center ? COLOR_BLACK : COLOR_GREY;
      // parity of the raster index row*w + col
      if (shadow_mode == MODE_FLICKER)
         return ((row * w + col) % 2 == 1) ? COLOR_DIM_GRN : COLOR_DIM_MAG;
      if (shadow_mode == MODE_CHECKER)
         return (cell_sum % 2 == 1) ? COLOR_WHITE : COLOR_BLACK;
      if (shadow_mode == MODE_BOX)
         return (col == 0 || col == w - 1 || row == 0 || row == h - 1) ?
                COLOR_WHITE : COLOR_BLACK;
      if (shadow_mode >= MODE_HRAMP_GREY && shadow_mode <= MODE_HRAMP_BLUE)
         return shade(ramp_step(col, w), 2'(shadow_mode - MODE_HRAMP_GREY));
      if (shadow_mode >= MODE_VRAMP_GREY && shadow_mode <= MODE_VRAMP_BLUE)
         return shade(ramp_step(row, h), 2'(shadow_mode - MODE_VRAMP_GREY));
      if (shadow_mode == MODE_HBARS)
         return BAR_SEQUENCE[edges_passed(col, w, BARS)];
      if (shadow_mode == MODE_VBARS)
         return BAR_SEQUENCE[edges_passed(row, h, BARS)];
      return COLOR_BLACK;   // unused mode
   endfunction

   // expected beat for one accepted request, then advance the raster
   function automatic pixel_beat_type next_raster_pixel(input logic restart_bit);
      pixel_beat_type beat;
      int             w;
      int             h;
      w = effective_size(shadow_width);
      h = effective_size(shadow_height);
      if (restart_bit) begin
         scan_col = 0;
         scan_row = 0;
      end
      // a shrunk panel pulls the position back onto its last column or row
      if (scan_col > w - 1)
         scan_col = w - 1;
      if (scan_row > h - 1)
         scan_row = h - 1;
      beat.rgb       = pattern_color(scan_col, scan_row, w, h);
      beat.line_end  = (scan_col == w - 1);
      beat.frame_end = beat.line_end && (scan_row == h - 1);
      if (beat.line_end) begin
         scan_col = 0;
         scan_row = beat.frame_end ? 0 : scan_row + 1;
      end else begin
         scan_col = scan_col + 1;
      end
      return beat;
   endfunction

   // ------------------------------------------------------------------
   // response side: ready pattern and beat checking
   // ------------------------------------------------------------------

   // receiver stalls at random, or holds off for a long stretch on request
   always @(posedge clock) begin : rsp_ready_gen
      int hold_left;
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // every response beat against the oldest expected pixel
   always @(posedge clock) begin : pixel_check
      pixel_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected beat: pixel_rgb %06h with no pixel pending",
                   rsp_bus.pixel_rgb);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_bus.pixel_rgb !== want.rgb) begin
               $error("pixel_rgb: expected %06h, got %06h", want.rgb, rsp_bus.pixel_rgb);
               error_count++;
            end
            if (rsp_bus.line_end !== want.line_end) begin
               $error("line_end: expected %0b, got %0b", want.line_end, rsp_bus.line_end);
               error_count++;
            end
            if (rsp_bus.frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, got %0b", want.frame_end,
                      rsp_bus.frame_end);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // request side and register port
   // ------------------------------------------------------------------

   task automatic set_flow(input flow_style_type style);
      case (style)
         FLOW_SENDER_GAPS:     begin req_idle_pct = 88; rsp_stall_pct = 0;  end
         FLOW_RECEIVER_STALLS: begin req_idle_pct = 0;  rsp_stall_pct = 88; end
         FLOW_BOTH_PAUSE:      begin req_idle_pct = 14; rsp_stall_pct = 14; end
         default:              begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
      endcase
   endtask

   // one request beat; valid stays high for a back-to-back follower
   task automatic send_pixel_request(input logic restart_bit);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart_bit;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      expected_pixels.push_back(next_raster_pixel(restart_bit));
      pixels_sent++;
   endtask

   // stop requesting and let every pending pixel come out
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0)
         @(posedge clock);
   endtask

   // setup and access phases, then idle; only with the stream empty
   task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                 input logic [DATA_W-1:0] value);
      wait_for_drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      case (idx)
         REG_MODE:   shadow_mode   = value[MODE_W-1:0];
         REG_WIDTH:  shadow_width  = value[SIZE_W-1:0];
         REG_HEIGHT: shadow_height = value[SIZE_W-1:0];
         REG_FILL:   shadow_fill   = value[RGB_W-1:0];
         default:    ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // read one register and compare its field with the shadow copy
   task automatic check_register(input logic [REG_IDX_W-1:0] idx);
      logic [DATA_W-1:0] got;
      logic [DATA_W-1:0] want;
      logic [DATA_W-1:0] field_mask;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_MODE:   begin want = DATA_W'(shadow_mode);   field_mask = (1 << MODE_W) - 1; end
         REG_WIDTH:  begin want = DATA_W'(shadow_width);  field_mask = (1 << SIZE_W) - 1; end
         REG_HEIGHT: begin want = DATA_W'(shadow_height); field_mask = (1 << SIZE_W) - 1; end
         default:    begin want = DATA_W'(shadow_fill);   field_mask = (1 << RGB_W) - 1;  end
      endcase
      if ((got & field_mask) !== want) begin
         $error("register %0d: expected %0h, got %0h", idx, want, got & field_mask);
         error_count++;
      end
      @(posedge clock);
   endtask

   // mostly small panels so that line and frame ends come often
   function automatic logic [DATA_W-1:0] pick_size(input int small_max);
      if ($urandom_range(9) != 0)
         return $urandom_range(small_max, 1);
      case ($urandom_range(4))
         0:       return 0;
         1:       return 1;
         2:       return DIM_MAX;
         3:       return $urandom_range(SIZE_CODE_MAX, DIM_MAX + 1);
         default: return $urandom_range(DIM_MAX, 1);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset values, then extreme codes written and read back
   task automatic test_register_access();
      for (int r = REG_MODE; r <= REG_FILL; r++)
         check_register(REG_IDX_W'(r));
      write_register(REG_MODE, MODE_UNUSED);
      write_register(REG_WIDTH, SIZE_CODE_MAX);
      write_register(REG_HEIGHT, 0);
      write_register(REG_FILL, 24'hFFFFFF);
      for (int r = REG_MODE; r <= REG_FILL; r++)
         check_register(REG_IDX_W'(r));
   endtask

   // zero size acts as one pixel, oversize as the panel limit
   task automatic test_size_corners();
      set_flow(FLOW_STEADY);
      write_register(REG_MODE, MODE_SOLID);
      write_register(REG_WIDTH, 0);
      write_register(REG_HEIGHT, 0);
      send_pixel_request(1'b1);
      send_pixel_request(1'b0);
      write_register(REG_MODE, MODE_BOX);
      write_register(REG_FILL, 0);
      write_register(REG_WIDTH, SIZE_CODE_MAX);
      write_register(REG_HEIGHT, DIM_MAX + 1);
      send_pixel_request(1'b1);
      send_pixel_request(1'b0);
   endtask

   // panel shrunk under the current position, in width then height
   task automatic test_frame_shrink();
      write_register(REG_MODE, MODE_HBARS);
      write_register(REG_WIDTH, 6);
      write_register(REG_HEIGHT, 3);
      send_pixel_request(1'b1);
      repeat (4) send_pixel_request(1'b0);
      write_register(REG_WIDTH, 2);
      send_pixel_request(1'b0);   // column 5 lands on column 1, line ends
      write_register(REG_HEIGHT, 1);
      send_pixel_request(1'b0);   // row 1 lands on row 0
   endtask

   // one pixel of each mode, the unused code too
   task automatic test_every_mode();
      write_register(REG_WIDTH, 3);
      write_register(REG_HEIGHT, 2);
      write_register(REG_FILL, $urandom_range(24'hFFFFFF));
      for (int m = MODE_SOLID; m <= MODE_UNUSED; m++) begin
         write_register(REG_MODE, m);
         send_pixel_request(m == MODE_SOLID);
      end
   endtask

   // random settings, random frames, all flow styles in rotation
   task automatic test_random_frames();
      int             phase;
      int             burst;
      flow_style_type style;
      phase = 0;
      while (pixels_sent < PIXEL_TARGET) begin
         style = flow_style_type'(phase % 4);
         if ($urandom_range(9) < 7)
            write_register(REG_MODE, $urandom_range(MODE_UNUSED, MODE_SOLID));
         if ($urandom_range(9) < 6)
            write_register(REG_WIDTH, pick_size(40));
         if ($urandom_range(9) < 6)
            write_register(REG_HEIGHT, pick_size(20));
         if ($urandom_range(9) < 3) begin
            case ($urandom_range(3))
               0:       write_register(REG_FILL, 0);
               1:       write_register(REG_FILL, 24'hFFFFFF);
               default: write_register(REG_FILL, $urandom_range(24'hFFFFFF));
            endcase
         end
         set_flow(style);
         burst = $urandom_range(80, 20);
         repeat (burst)
            send_pixel_request($urandom_range(99) < 3);
         phase++;
      end
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_output_backpressure();
      write_register(REG_MODE, MODE_CHECKER);
      write_register(REG_WIDTH, 9);
      write_register(REG_HEIGHT, 4);
      set_flow(FLOW_STEADY);
      hold_request = 1'b1;
      repeat (40) send_pixel_request(1'b0);
   endtask

   // sender waits for every pixel before the next burst
   task automatic test_drain_pauses();
      write_register(REG_MODE, MODE_CROSSTALK);
      write_register(REG_WIDTH, 8);
      write_register(REG_HEIGHT, 4);
      set_flow(FLOW_BOTH_PAUSE);
      for (int b = 0; b < 3; b++) begin
         repeat (15) send_pixel_request(1'b0);
         wait_for_drain();
      end
   endtask

   initial begin
      // every input known from time zero
      req_bus.valid   = 1'b0;
      req_bus.restart = 1'b0;
      rsp_bus.ready   = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_size_corners();
      test_frame_shrink();
      test_every_mode();
      test_output_backpressure();
      test_drain_pauses();
      test_random_frames();

      // all pixels out, then a quiet tail for anything stray
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
